@@ src/fesc_pkg.sv @@
package fesc_pkg;

  localparam int COORD_W     = 4;
  localparam int PORT_W      = 3;
  localparam int KIND_W      = 3;
  localparam int INDEX_W     = 6;
  localparam int COUNT_W     = 16;
  localparam int PLEN_W      = 7;
  localparam int STATUS_W    = 4;
  localparam int IN_DATA_W   = 40;
  localparam int IN_USER_W   = 3;
  localparam int OUT_DATA_W  = 24;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 7;

  typedef enum logic [KIND_W-1:0] {
    KIND_HEAD   = 3'd0,
    KIND_BODY   = 3'd1,
    KIND_TAIL   = 3'd2,
    KIND_SINGLE = 3'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 4'd0,
    ST_SEQ   = 4'd1,
    ST_DEST  = 4'd2,
    ST_SRC   = 4'd3,
    ST_SENT  = 4'd4,
    ST_INDEX = 4'd5,
    ST_LEN   = 4'd6,
    ST_KIND  = 4'd7,
    ST_WARN  = 4'd8
  } status_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_LOCAL_X       = 2'd0,
    CFG_LOCAL_Y       = 2'd1,
    CFG_LOCAL_Z       = 2'd2,
    CFG_PACKET_LENGTH = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_W-1:0] z;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } coord_t;

  typedef struct packed {
    logic [PORT_W-1:0]  port;
    logic [KIND_W-1:0]  kind;
    logic [INDEX_W-1:0] index;
    coord_t             source;
    coord_t             dest;
    logic               sent;
  } flit_t;

  typedef struct packed {
    logic               receiving;
    logic [INDEX_W-1:0] expected_index;
    coord_t             held_source;
    logic [COUNT_W-1:0] count;
  } port_entry_t;

  typedef struct packed {
    coord_t            node;
    logic [PLEN_W-1:0] packet_length;
  } cfg_t;

  typedef struct packed {
    logic [PORT_W-1:0]  port_out;
    status_t            status;
    logic               done;
    logic [COUNT_W-1:0] count;
  } result_t;

endpackage

@@ src/fesc_port_state.sv @@
module fesc_port_state #(
  parameter int PORTS = 6
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [fesc_pkg::PORT_W-1:0] port,
  output fesc_pkg::port_entry_t       rd_entry,
  input  logic                        wr_en,
  input  fesc_pkg::port_entry_t       wr_entry
);
  import fesc_pkg::*;

  port_entry_t entry_r [PORTS];

  // Ports outside the table read as an idle, empty entry and are never written.
  always_comb begin
    rd_entry = '0;
    for (int p = 0; p < PORTS; p++) begin
      if (int'(port) == p) begin
        rd_entry = entry_r[p];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < PORTS; p++) begin
        entry_r[p] <= '0;
      end
    end else if (wr_en) begin
      for (int p = 0; p < PORTS; p++) begin
        if (int'(port) == p) begin
          entry_r[p] <= wr_entry;
        end
      end
    end
  end

endmodule

@@ src/fesc_check.sv @@
module fesc_check #(
  parameter int PORTS            = 6,
  parameter int MAX_PACKET_FLITS = 64
) (
  input  fesc_pkg::flit_t       flit,
  input  fesc_pkg::port_entry_t entry,
  input  fesc_pkg::cfg_t        cfg,
  output fesc_pkg::result_t     res,
  output fesc_pkg::port_entry_t entry_nxt
);
  import fesc_pkg::*;

  logic               port_ok;
  logic               dest_ok;
  logic               src_ok;
  logic               len_ok;
  logic [INDEX_W-1:0] inc;
  logic [INDEX_W-1:0] next_index;
  logic [COUNT_W-1:0] count_inc;
  status_t            status;
  logic               done;

  assign port_ok   = int'(flit.port) < PORTS;
  assign dest_ok   = (flit.dest == cfg.node);
  assign src_ok    = (flit.source == entry.held_source);
  // The tail length compare is done without wrap on the index.
  assign len_ok    = (PLEN_W'({1'b0, entry.expected_index}) + PLEN_W'(1)) ==
                     cfg.packet_length;
  assign inc       = entry.expected_index + INDEX_W'(1);
  assign next_index = (int'(inc) >= MAX_PACKET_FLITS) ? '0 : inc;
  assign count_inc = entry.count + COUNT_W'(1);

  // Checks run in a fixed order; the first failure wins and keeps the state.
  always_comb begin
    status    = ST_OK;
    done      = 1'b0;
    entry_nxt = entry;
    case (flit.kind) inside
      KIND_HEAD: begin
        if (entry.receiving)                       status = ST_SEQ;
        else if (!dest_ok)                         status = ST_DEST;
        else if (!flit.sent)                       status = ST_SENT;
        else if (flit.index != entry.expected_index) status = ST_INDEX;
        else begin
          entry_nxt.expected_index = next_index;
          entry_nxt.receiving      = 1'b1;
          entry_nxt.held_source    = flit.source;
        end
      end
      KIND_BODY, KIND_TAIL: begin
        if (!entry.receiving)                      status = ST_SEQ;
        else if (!dest_ok)                         status = ST_DEST;
        else if (!src_ok)                          status = ST_SRC;
        else if (!flit.sent)                       status = ST_SENT;
        else if (flit.kind == KIND_TAIL && !len_ok) status = ST_LEN;
        else if (flit.index != entry.expected_index) status = ST_INDEX;
        else if (flit.kind == KIND_BODY) begin
          entry_nxt.expected_index = next_index;
        end else begin
          entry_nxt.expected_index = '0;
          entry_nxt.receiving      = 1'b0;
          entry_nxt.count          = count_inc;
          done                     = 1'b1;
        end
      end
      KIND_SINGLE: begin
        if (entry.receiving)                       status = ST_SEQ;
        else if (!dest_ok)                         status = ST_DEST;
        else if (!flit.sent)                       status = ST_SENT;
        else if (flit.index != '0)                 status = ST_INDEX;
        else begin
          entry_nxt.count = count_inc;
          done            = 1'b1;
          if (cfg.packet_length != PLEN_W'(1)) status = ST_WARN;
        end
      end
      default: status = ST_KIND;
    endcase
  end

  always_comb begin
    res.port_out = flit.port;
    if (port_ok) begin
      res.status = status;
      res.done   = done;
      res.count  = entry_nxt.count;
    end else begin
      res.status = ST_SEQ;
      res.done   = 1'b0;
      res.count  = '0;
    end
  end

endmodule

@@ src/flit_stream_eject_checker_core.sv @@
// Eject-side flit sequence checker for a wormhole network node.
// Each request on the in_ channel is one flit ejected on one of PORTS ports.
// It is checked against that port's receive state (idle or receiving, the
// expected flit index and the source latched from the head flit), and one
// result request leaves on the out_ channel for every flit taken in.
// The cfg_ channel writes the node coordinates and the expected packet
// length; it is always ready and is meant to be used while no flit is in
// flight.
// Each accepted flit waits in the input register, where the port entry is
// read and checked, and then moves into the result register, loaded at
// the edge that writes the entry back; out_tvalid rises once it is loaded.
// Throughput is one flit per cycle while the result register can move,
// since a port's state is written back at the same edge that loads the
// next flit into the input register, which then reads the updated entry.
// A result left waiting on a low out_tready holds its value; the input
// register keeps taking a flit as long as the result register can move,
// and in_tready drops only when both stages are full and out_tready is low.
// A synchronous reset (rst_n low) empties both stages, sets every port idle
// with zero index, source and packet count, and loads the reset configuration.
module flit_stream_eject_checker_core #(
  parameter int PORTS            = 6,
  parameter int MAX_PACKET_FLITS = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata, from bit 0: port[3], flit_index[6], source_x/y/z[4 each],
  // dest_x/y/z[4 each], packet_was_sent[1], zero padding.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [fesc_pkg::IN_DATA_W-1:0]   in_tdata,
  // in_tuser: flit_kind[3].
  input  logic [fesc_pkg::IN_USER_W-1:0]   in_tuser,
  // out_tdata, from bit 0: port_out[3], status[4], packets_received[16],
  // zero padding.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [fesc_pkg::OUT_DATA_W-1:0]  out_tdata,
  // out_tlast: packet_done.
  output logic                             out_tlast,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fesc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fesc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import fesc_pkg::*;

  cfg_t        cfg_r;
  cfg_t        cfg_nxt;
  logic        s1_valid_r;
  logic        s1_valid_nxt;
  flit_t       s1_flit_r;
  logic        out_valid_r;
  logic        out_valid_nxt;
  result_t     out_res_r;
  flit_t       in_flit;
  port_entry_t rd_entry;
  port_entry_t entry_nxt;
  result_t     res;
  logic        in_fire;
  logic        out_load;

  // Unpack the incoming request.
  assign in_flit.port   = in_tdata[2:0];
  assign in_flit.index  = in_tdata[8:3];
  assign in_flit.source.x = in_tdata[12:9];
  assign in_flit.source.y = in_tdata[16:13];
  assign in_flit.source.z = in_tdata[20:17];
  assign in_flit.dest.x = in_tdata[24:21];
  assign in_flit.dest.y = in_tdata[28:25];
  assign in_flit.dest.z = in_tdata[32:29];
  assign in_flit.sent   = in_tdata[33];
  assign in_flit.kind   = in_tuser;

  // The checked flit moves into the result register whenever that register
  // is empty or being drained; the port entry is updated at the same edge.
  assign out_load  = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || out_load;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LOCAL_X:       cfg_nxt.node.x        = cfg_data[COORD_W-1:0];
        CFG_LOCAL_Y:       cfg_nxt.node.y        = cfg_data[COORD_W-1:0];
        CFG_LOCAL_Z:       cfg_nxt.node.z        = cfg_data[COORD_W-1:0];
        CFG_PACKET_LENGTH: cfg_nxt.packet_length = cfg_data;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (out_load) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.node          <= '0;
      cfg_r.packet_length <= PLEN_W'(1);
      s1_valid_r          <= 1'b0;
      out_valid_r         <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_flit_r <= in_flit;
    end
    if (out_load) begin
      out_res_r <= res;
    end
  end

  fesc_port_state #(
    .PORTS(PORTS)
  ) u_state (
    .clk      (clk),
    .rst_n    (rst_n),
    .port     (s1_flit_r.port),
    .rd_entry (rd_entry),
    .wr_en    (out_load),
    .wr_entry (entry_nxt)
  );

  fesc_check #(
    .PORTS            (PORTS),
    .MAX_PACKET_FLITS (MAX_PACKET_FLITS)
  ) u_check (
    .flit      (s1_flit_r),
    .entry     (rd_entry),
    .cfg       (cfg_r),
    .res       (res),
    .entry_nxt (entry_nxt)
  );

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_res_r.done;
  assign out_tdata  = {1'b0, out_res_r.count, out_res_r.status, out_res_r.port_out};

endmodule

@@ src/fesc_checker.sv @@
module fesc_checker #(
  parameter int PORTS = 6
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [fesc_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                            out_tlast
);
  import fesc_pkg::*;

  logic [PORT_W-1:0]   port_out;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  count;

  assign port_out = out_tdata[2:0];
  assign status   = out_tdata[6:3];
  assign count    = out_tdata[22:7];

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A stalled result keeps its value.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // A completed packet only comes with a passing or warning status.
  a_done_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> status == ST_OK || status == ST_WARN)
    else $error("packet done with failing status");

  // A port outside the table reports a sequence error with no count.
  a_bad_port: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && int'(port_out) >= PORTS |->
      status == ST_SEQ && count == '0 && !out_tlast)
    else $error("bad port result wrong");

endmodule

bind flit_stream_eject_checker_core fesc_checker #(
  .PORTS(PORTS)
) u_fesc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

@@ sim/flit_stream_eject_checker_core_test.sv @@
`timescale 1ns / 1ps

// Testbench for the eject-side flit sequence checker.
//
// Flits are sent as requests on the in_ channel. At the moment each one is
// accepted, a per-port model of the wormhole receive state works out the
// result request that the block must return for it. That result is queued in
// order. A separate process pops the queue for every result request taken on
// the out_ channel and compares port, status, packet_done and the packet
// count field by field.
//
// The run starts with a short directed part: the reset configuration, most
// checks of the fixed check order for head, body, tail and single flits,
// unknown kinds, ports beyond the last one, and the tail length check with
// packet lengths of zero and beyond the index range. A long receiver hold-off
// then fills the block so that it stalls its input. The bulk of the run is
// random traffic in phases with different node coordinates and packet
// lengths. Most flits are the legal next flit of an interleaved packet on a
// random port, and the rest are damaged in one field or fully random.
// The configuration is only rewritten once every result has come back.
module flit_stream_eject_checker_core_test;
  import fesc_pkg::*;

  localparam int NUM_PORTS   = 6;
  localparam int MAX_FLITS   = 64;
  localparam int DRAIN_LIMIT = 20000;
  localparam int TIMEOUT_NS  = 4_000_000;
  localparam int PRINT_LIMIT = 40;

  // Flit kinds that the block must reject with a bad-kind status.
  localparam logic [KIND_W-1:0] KIND_BAD_LO = 3'd4;
  localparam logic [KIND_W-1:0] KIND_BAD_HI = 3'd7;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata;
  logic [IN_USER_W-1:0]   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic                   out_tlast;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  flit_stream_eject_checker_core #(
    .PORTS            (NUM_PORTS),
    .MAX_PACKET_FLITS (MAX_FLITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model of the node configuration and of each port's receive state. It is
  // updated at the clock edge where a flit or a register write is accepted.
  coord_t            cfg_node;
  logic [PLEN_W-1:0] cfg_plen;
  logic              rx_busy   [NUM_PORTS];
  logic [INDEX_W-1:0] rx_index [NUM_PORTS];
  coord_t            rx_source [NUM_PORTS];
  logic [COUNT_W-1:0] rx_count [NUM_PORTS];

  // Results still owed by the block, oldest first.
  result_t awaited_results[$];

  int error_count = 0;
  int burst_left  = 0;
  int hold_left   = 0;
  int stall_cycle = 0;
  int stall_mode  = 0;

  task automatic report_error(string msg);
    if (error_count < PRINT_LIMIT) begin
      $display("%0t ERROR %s", $time, msg);
    end
    error_count++;
  endtask

  // Applies one flit to the port model and returns the result it must cause.
  // The checks run in the block's fixed order, and the first one that fails
  // sets the status and leaves the port entry untouched.
  function automatic result_t eject_check(flit_t f);
    result_t            r;
    logic               dest_ok;
    logic [PORT_W-1:0]  p;
    p          = f.port;
    r.port_out = f.port;
    r.status   = ST_OK;
    r.done     = 1'b0;
    r.count    = '0;
    // A port beyond the last one reports a bad sequence and a zero count.
    if (f.port >= NUM_PORTS) begin
      r.status = ST_SEQ;
      return r;
    end
    dest_ok = (f.dest == cfg_node);
    case (f.kind) inside
      KIND_HEAD: begin
        if (rx_busy[p]) r.status = ST_SEQ;
        else if (!dest_ok) r.status = ST_DEST;
        else if (!f.sent) r.status = ST_SENT;
        else if (f.index != rx_index[p]) r.status = ST_INDEX;
        else begin
          // The 6-bit index wraps to zero after the last flit position.
          rx_index[p]  = rx_index[p] + 1'b1;
          rx_busy[p]   = 1'b1;
          rx_source[p] = f.source;
        end
      end
      KIND_BODY, KIND_TAIL: begin
        if (!rx_busy[p]) r.status = ST_SEQ;
        else if (!dest_ok) r.status = ST_DEST;
        else if (f.source != rx_source[p]) r.status = ST_SRC;
        else if (!f.sent) r.status = ST_SENT;
        // The length compare does not wrap, so a length of zero or above 64
        // can never close a packet.
        else if (f.kind == KIND_TAIL && {1'b0, rx_index[p]} + 7'd1 != cfg_plen)
          r.status = ST_LEN;
        else if (f.index != rx_index[p]) r.status = ST_INDEX;
        else if (f.kind == KIND_BODY) rx_index[p] = rx_index[p] + 1'b1;
        else begin
          rx_index[p] = '0;
          rx_busy[p]  = 1'b0;
          rx_count[p] = rx_count[p] + 1'b1;
          r.done      = 1'b1;
        end
      end
      KIND_SINGLE: begin
        if (rx_busy[p]) r.status = ST_SEQ;
        else if (!dest_ok) r.status = ST_DEST;
        else if (!f.sent) r.status = ST_SENT;
        else if (f.index != '0) r.status = ST_INDEX;
        else begin
          // Accepted either way, but flagged when packets should be longer.
          rx_count[p] = rx_count[p] + 1'b1;
          r.done      = 1'b1;
          if (cfg_plen != 7'd1) r.status = ST_WARN;
        end
      end
      default: r.status = ST_KIND;
    endcase
    r.count = rx_count[p];
    return r;
  endfunction

  function automatic coord_t rand_coord();
    logic [3*COORD_W-1:0] b;
    b = (3*COORD_W)'($urandom);
    return b;
  endfunction

  function automatic flit_t make_flit(int port, int kind, int index, coord_t source,
                                      coord_t dest, logic sent);
    flit_t f;
    f.port   = PORT_W'(port);
    f.kind   = KIND_W'(kind);
    f.index  = INDEX_W'(index);
    f.source = source;
    f.dest   = dest;
    f.sent   = sent;
    return f;
  endfunction

  // The legal next flit for a port, given what the port model holds now.
  function automatic flit_t next_flit(logic [PORT_W-1:0] p);
    flit_t f;
    f = make_flit(p, KIND_HEAD, rx_index[p], rx_source[p], cfg_node, 1'b1);
    if (!rx_busy[p]) begin
      f.source = rand_coord();
      if (cfg_plen == 7'd1 || $urandom_range(9) == 0) begin
        f.kind  = KIND_SINGLE;
        f.index = '0;
      end
    end else if ({1'b0, rx_index[p]} + 7'd1 == cfg_plen) begin
      f.kind = KIND_TAIL;
    end else begin
      f.kind = KIND_BODY;
    end
    return f;
  endfunction

  // Breaks one field of a flit, or replaces it with random bits altogether.
  function automatic flit_t damage_flit(flit_t f);
    logic [63:0] rbits;
    rbits = {$urandom, $urandom};
    case ($urandom_range(6))
      0: f.kind = KIND_W'($urandom_range(7));
      1: f.index = INDEX_W'($urandom_range(MAX_FLITS - 1));
      2: f.dest = rand_coord();
      3: f.source = rand_coord();
      4: f.sent = 1'b0;
      5: f.port = PORT_W'($urandom_range(7));
      default: f = rbits[$bits(flit_t)-1:0];
    endcase
    return f;
  endfunction

  // Sends one flit request. The sender works in bursts of random length,
  // with a random gap, sometimes none, ahead of each burst.
  task automatic send_flit(flit_t f);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= f.kind;
    in_tdata  <= {6'd0, f.sent, f.dest.z, f.dest.y, f.dest.x,
                  f.source.z, f.source.y, f.source.x, f.index, f.port};
    do @(posedge clk); while (!in_tready);
    awaited_results.push_back(eject_check(f));
    burst_left--;
  endtask

  task automatic write_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    case (r)
      CFG_LOCAL_X:       cfg_node.x = v[COORD_W-1:0];
      CFG_LOCAL_Y:       cfg_node.y = v[COORD_W-1:0];
      CFG_LOCAL_Z:       cfg_node.z = v[COORD_W-1:0];
      CFG_PACKET_LENGTH: cfg_plen   = v;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_node(coord_t node);
    write_reg(CFG_LOCAL_X, {3'b0, node.x});
    write_reg(CFG_LOCAL_Y, {3'b0, node.y});
    write_reg(CFG_LOCAL_Z, {3'b0, node.z});
  endtask

  // Stops sending, waits for every owed result and then lets the block settle,
  // so that the block is idle before the configuration changes.
  task automatic drain_results();
    int waited;
    waited = 0;
    @(negedge clk);
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (awaited_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    foreach (awaited_results[i]) begin
      report_error($sformatf("no result came for a flit on port %0d",
                             awaited_results[i].port_out));
    end
    awaited_results.delete();
    repeat (4) @(posedge clk);
  endtask

  // Result checker: each result request taken is matched with the oldest
  // expectation. out_tdata holds port_out in [2:0], status in [6:3] and the
  // packet count in [22:7]; out_tlast carries packet_done.
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_results.size() == 0) begin
        report_error($sformatf("unexpected result on port %0d", out_tdata[2:0]));
      end else begin
        want = awaited_results.pop_front();
        if (out_tdata[2:0] != want.port_out)
          report_error($sformatf("port_out %0d, expected %0d",
                                 out_tdata[2:0], want.port_out));
        if (out_tdata[6:3] != want.status)
          report_error($sformatf("port %0d status %0d, expected %0d",
                                 want.port_out, out_tdata[6:3], want.status));
        if (out_tlast != want.done)
          report_error($sformatf("port %0d packet_done %0b, expected %0b",
                                 want.port_out, out_tlast, want.done));
        if (out_tdata[22:7] != want.count)
          report_error($sformatf("port %0d packet count %0d, expected %0d",
                                 want.port_out, out_tdata[22:7], want.count));
      end
    end
  end

  // Receiver: a stall pattern, drawn at random again and again from always
  // ready, mostly ready, mostly stalled and alternating. A hold-off request
  // from the test forces it low first, for as long as hold_left counts down.
  always @(negedge clk) begin
    if (stall_cycle % 128 == 0) stall_mode = $urandom_range(3);
    stall_cycle++;
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(3) != 0);
        2: out_tready <= ($urandom_range(3) == 0);
        default: out_tready <= stall_cycle[0];
      endcase
    end
  end

  // Reset configuration: node 0,0,0 and one-flit packets.
  task automatic test_reset_defaults();
    coord_t src_a;
    src_a = 12'h35A;
    send_flit(make_flit(0, KIND_SINGLE, 0, src_a, '0, 1'b1));
    send_flit(make_flit(5, KIND_SINGLE, 0, src_a, '0, 1'b1));
    // This head leaves port 1 mid-packet for the length tests further on.
    send_flit(make_flit(1, KIND_HEAD, 0, src_a, '0, 1'b1));
    send_flit(make_flit(1, KIND_TAIL, 1, src_a, '0, 1'b1));
  endtask

  // Checks of the check order, one at a time, on a node far from zero.
  task automatic test_check_order();
    coord_t far_node, off_node, src_a, src_b;
    far_node   = '1;
    off_node   = far_node;
    off_node.x = 4'hE;
    src_a      = 12'h35A;
    src_b      = 12'h35B;
    drain_results();
    write_node(far_node);
    write_reg(CFG_PACKET_LENGTH, 7'd3);
    send_flit(make_flit(2, KIND_HEAD, 0, src_a, far_node, 1'b1));
    send_flit(make_flit(2, KIND_HEAD, 1, src_a, far_node, 1'b1));
    send_flit(make_flit(2, KIND_BODY, 1, src_a, off_node, 1'b1));
    send_flit(make_flit(2, KIND_BODY, 1, src_b, far_node, 1'b1));
    send_flit(make_flit(2, KIND_BODY, 1, src_a, far_node, 1'b0));
    send_flit(make_flit(2, KIND_TAIL, 1, src_a, far_node, 1'b1));
    send_flit(make_flit(2, KIND_BODY, 5, src_a, far_node, 1'b1));
    send_flit(make_flit(2, KIND_BODY, 1, src_a, far_node, 1'b1));
    send_flit(make_flit(2, KIND_TAIL, 2, src_a, far_node, 1'b1));
    send_flit(make_flit(3, KIND_BODY, 0, src_a, far_node, 1'b1));
    // Single flit while packets should be three flits long: a warning.
    send_flit(make_flit(3, KIND_SINGLE, 0, src_b, far_node, 1'b1));
    send_flit(make_flit(4, KIND_SINGLE, 1, src_b, far_node, 1'b1));
    send_flit(make_flit(4, KIND_SINGLE, 0, src_b, far_node, 1'b0));
    send_flit(make_flit(4, KIND_HEAD, 3, src_b, far_node, 1'b1));
    send_flit(make_flit(4, KIND_SINGLE, 0, src_b, off_node, 1'b1));
    send_flit(make_flit(0, KIND_BAD_LO, 0, src_a, far_node, 1'b1));
    send_flit(make_flit(0, KIND_BAD_HI, 0, src_a, far_node, 1'b1));
    send_flit(make_flit(NUM_PORTS, KIND_HEAD, 0, src_a, far_node, 1'b1));
    send_flit(make_flit(NUM_PORTS + 1, KIND_SINGLE, 0, src_a, far_node, 1'b1));
  endtask

  // Port 1 waits at index 1. Lengths of zero and 127 can never close it;
  // a length of two then does.
  task automatic test_length_extremes();
    coord_t src_a;
    src_a = 12'h35A;
    drain_results();
    write_reg(CFG_PACKET_LENGTH, 7'd0);
    send_flit(make_flit(1, KIND_TAIL, 1, src_a, cfg_node, 1'b1));
    drain_results();
    write_reg(CFG_PACKET_LENGTH, 7'd127);
    send_flit(make_flit(1, KIND_TAIL, 1, src_a, cfg_node, 1'b1));
    drain_results();
    write_reg(CFG_PACKET_LENGTH, 7'd2);
    send_flit(make_flit(1, KIND_TAIL, 1, src_a, cfg_node, 1'b1));
  endtask

  // The receiver holds off for a long stretch while the sender keeps going,
  // so that both stages fill up and in_tready drops.
  task automatic test_receiver_holdoff();
    drain_results();
    write_reg(CFG_PACKET_LENGTH, 7'd4);
    for (int i = 0; i < 60; i++) begin
      if (i == 10) hold_left = 100;
      send_flit(next_flit($urandom_range(NUM_PORTS - 1)));
    end
  endtask

  // Random packet traffic in phases. Each phase starts idle with a new node
  // position and packet length, the extremes among them.
  task automatic test_random_traffic();
    logic [PLEN_W-1:0] lengths [7] = '{7'd1, 7'd64, 7'd3, 7'd2, 7'd5, 7'd1, 7'd8};
    coord_t            node;
    flit_t             f;
    for (int phase = 0; phase < 7; phase++) begin
      drain_results();
      if (phase == 0) node = '0;
      else if (phase == 1) node = '1;
      else node = rand_coord();
      write_node(node);
      write_reg(CFG_PACKET_LENGTH, lengths[phase]);
      for (int i = 0; i < 255; i++) begin
        f = next_flit($urandom_range(NUM_PORTS - 1));
        if ($urandom_range(99) < 15) f = damage_flit(f);
        send_flit(f);
      end
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_LOCAL_X;
    cfg_data  = '0;
    cfg_node  = '0;
    cfg_plen  = 7'd1;
    foreach (rx_busy[p]) begin
      rx_busy[p]   = 1'b0;
      rx_index[p]  = '0;
      rx_source[p] = '0;
      rx_count[p]  = '0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_check_order();
    test_length_extremes();
    test_receiver_holdoff();
    test_random_traffic();

    drain_results();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Hard limit on the run, far beyond the slowest correct run.
  initial begin
    #(TIMEOUT_NS);
    $display("timeout");
    $display("DONE: errors detected");
    $finish;
  end

endmodule
